@@ rtl/sdno_pkg.sv @@
// Shared types, constants and the 3x5 digit font for the decimal number overlay.
// Used by sdno_bcd and the top level; no dependencies.
`default_nettype none

package sdno_pkg;

  localparam int CoordBits        = 12;
  localparam int ScaleW           = 4;
  localparam int ValueW           = 32;
  localparam int ColorW           = 16;
  localparam int CfgIdxW          = 3;
  localparam int CfgDataW         = 32;
  localparam int BcdDigits        = 10;
  localparam int DigitW           = 4;
  localparam int DigitCntW        = 4;
  localparam int GlyphRows        = 5;
  localparam int GlyphCols        = 3;
  localparam int DivSteps         = 4;
  localparam int MaxDigitsDefault = 10;

  localparam logic [ScaleW-1:0] ScaleReset = ScaleW'(1);
  localparam logic [ColorW-1:0] InkReset   = '1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ORIGIN_X    = 3'd0,
    REG_ORIGIN_Y    = 3'd1,
    REG_SHOWN_VALUE = 3'd2,
    REG_SCALE       = 3'd3,
    REG_INK_COLOR   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [CoordBits-1:0] pixel_x;
    logic [CoordBits-1:0] pixel_y;
  } pix_in_t;

  typedef struct packed {
    logic              lit;
    logic [ColorW-1:0] pixel_color;
  } pix_out_t;

  typedef struct packed {
    logic                 busy;
    logic [DigitCntW-1:0] count;
  } digit_stat_t;

  typedef logic [BcdDigits-1:0][DigitW-1:0] digits_t;

  // bit 2 is the leftmost font column
  localparam logic [GlyphCols-1:0] GLYPH_ROWS [BcdDigits][GlyphRows] = '{
    '{3'd7, 3'd5, 3'd5, 3'd5, 3'd7},
    '{3'd2, 3'd6, 3'd2, 3'd2, 3'd7},
    '{3'd7, 3'd1, 3'd7, 3'd4, 3'd7},
    '{3'd7, 3'd1, 3'd3, 3'd1, 3'd7},
    '{3'd5, 3'd5, 3'd7, 3'd1, 3'd1},
    '{3'd7, 3'd4, 3'd7, 3'd1, 3'd7},
    '{3'd7, 3'd4, 3'd7, 3'd5, 3'd7},
    '{3'd7, 3'd1, 3'd2, 3'd4, 3'd4},
    '{3'd7, 3'd5, 3'd7, 3'd5, 3'd7},
    '{3'd7, 3'd5, 3'd7, 3'd1, 3'd7}
  };

  function automatic logic glyph_bit(logic [DigitW-1:0] digit, logic [2:0] row,
                                     logic [1:0] col);
    logic [GlyphCols-1:0] pat;
    logic                 res;
    pat = '0;
    res = 1'b0;
    if (digit < DigitW'(BcdDigits) && row < 3'(GlyphRows) && col < 2'(GlyphCols)) begin
      pat = GLYPH_ROWS[digit][row];
      res = pat[2'd2 - col];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ rtl/sdno_bcd.sv @@
// Binary to decimal converter for the displayed value, eight value bits per cycle,
// with digit count. Depends on sdno_pkg.
`default_nettype none

module sdno_bcd #(
  parameter int MAX_DIGITS = sdno_pkg::MaxDigitsDefault
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [sdno_pkg::ValueW-1:0] value_i,
  output sdno_pkg::digits_t               digits_o,
  output sdno_pkg::digit_stat_t           stat_o
);
  import sdno_pkg::*;

  localparam int StepBits = 8;
  localparam int NSteps   = ValueW / StepBits;
  localparam int CntW     = $clog2(NSteps);
  localparam int BcdW     = BcdDigits * DigitW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_COUNT
  } state_e;

  state_e               state_q;
  logic [ValueW-1:0]    bin_q;
  logic [CntW-1:0]      cnt_q;
  digits_t              bcd_q;
  logic [DigitCntW-1:0] count_q;

  digits_t              dab;
  logic [DigitCntW-1:0] count_d;

  function automatic digits_t dabble(digits_t b, logic [StepBits-1:0] bits);
    digits_t       r;
    logic [BcdW:0] sh;
    r  = b;
    sh = '0;
    for (int k = StepBits - 1; k >= 0; k--) begin
      for (int i = 0; i < BcdDigits; i++) begin
        if (r[i] >= DigitW'(5)) begin
          r[i] = r[i] + DigitW'(3);
        end
      end
      sh = {r, bits[k]};
      r  = sh[BcdW-1:0];
    end
    return r;
  endfunction

  assign dab = dabble(bcd_q, bin_q[ValueW-1 -: StepBits]);

  always_comb begin
    count_d = DigitCntW'(1);
    for (int i = 0; i < BcdDigits; i++) begin
      if (bcd_q[i] != '0) begin
        count_d = DigitCntW'(i + 1);
      end
    end
    if (int'(count_d) > MAX_DIGITS) begin
      count_d = DigitCntW'(MAX_DIGITS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      bin_q   <= '0;
      cnt_q   <= '0;
      bcd_q   <= '0;
      count_q <= DigitCntW'(1);
    end else if (start_i) begin
      state_q <= ST_SHIFT;
      bin_q   <= value_i;
      cnt_q   <= '0;
      bcd_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
        end
        ST_SHIFT: begin
          bcd_q <= dab;
          bin_q <= {bin_q[ValueW-StepBits-1:0], {StepBits{1'b0}}};
          cnt_q <= cnt_q + CntW'(1);
          if (cnt_q == CntW'(NSteps - 1)) begin
            state_q <= ST_COUNT;
          end
        end
        ST_COUNT: begin
          count_q <= count_d;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign digits_o     = bcd_q;
  assign stat_o.busy  = (state_q != ST_IDLE);
  assign stat_o.count = count_q;

endmodule

`default_nettype wire

@@ rtl/sdno_div.sv @@
// Pipelined restoring divider: several lanes share one small divisor, a tag rides along.
// Depends on sdno_pkg only through the caller; standalone logic.
`default_nettype none

module sdno_div #(
  parameter int W     = 12,
  parameter int NL    = 2,
  parameter int SW    = 4,
  parameter int TAG_W = 1,
  parameter int STEPS = 4
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire logic                   valid_i,
  input  wire logic [NL-1:0][W-1:0]   dividend_i,
  input  wire logic [SW-1:0]          divisor_i,
  input  wire logic [TAG_W-1:0]       tag_i,
  output logic                        valid_o,
  output logic [NL-1:0][W-1:0]        quot_o,
  output logic [TAG_W-1:0]            tag_o
);

  localparam int NSTAGE = (W + STEPS - 1) / STEPS;
  localparam int RW     = SW + 1;

  typedef struct packed {
    logic [W-1:0]  dv;
    logic [RW-1:0] rem;
    logic [W-1:0]  quo;
  } lane_t;

  logic [NSTAGE-1:0]     vld_q;
  lane_t [NL-1:0]        lane_q [NSTAGE];
  logic [TAG_W-1:0]      tag_q  [NSTAGE];

  function automatic lane_t div_steps(lane_t a, logic [SW-1:0] d, int base);
    lane_t       r;
    logic [RW-1:0] t;
    r = a;
    for (int k = 0; k < STEPS; k++) begin
      if (base + k < W) begin
        t    = {r.rem[RW-2:0], r.dv[W-1]};
        r.dv = {r.dv[W-2:0], 1'b0};
        if (t >= {1'b0, d}) begin
          r.rem = t - {1'b0, d};
          r.quo = {r.quo[W-2:0], 1'b1};
        end else begin
          r.rem = t;
          r.quo = {r.quo[W-2:0], 1'b0};
        end
      end
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NSTAGE-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < NL; l++) begin
        lane_q[0][l] <= div_steps('{dv: dividend_i[l], rem: '0, quo: '0}, divisor_i, 0);
      end
      tag_q[0] <= tag_i;
      for (int s = 1; s < NSTAGE; s++) begin
        for (int l = 0; l < NL; l++) begin
          lane_q[s][l] <= div_steps(lane_q[s-1][l], divisor_i, s * STEPS);
        end
        tag_q[s] <= tag_q[s-1];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      quot_o[l] = lane_q[NSTAGE-1][l].quo;
    end
  end

  assign valid_o = vld_q[NSTAGE-1];
  assign tag_o   = tag_q[NSTAGE-1];

endmodule

`default_nettype wire

@@ rtl/scaled_decimal_number_overlay.sv @@
// Top level of the scaled 3x5 decimal number overlay.
// Depends on sdno_pkg, sdno_bcd and sdno_div.
//
// Each transaction on the input channel is one screen coordinate; the block
// answers with one transaction telling whether that pixel lies on a stroke of
// the configured number and its color. One coordinate is taken every clock unless
// the output stalls or a conversion is busy; the result passes the offset stage,
// the pipelined divide-by-scale (four quotient bits per stage), the digit select
// and output stages. A write to shown_value starts a binary to decimal
// conversion, eight value bits per cycle, that holds the input stalled while
// it runs (four conversion steps, plus one to count digits).
`default_nettype none

module scaled_decimal_number_overlay #(
  parameter int MAX_DIGITS = sdno_pkg::MaxDigitsDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire sdno_pkg::pix_in_t            in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output sdno_pkg::pix_out_t                out_data_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [sdno_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [sdno_pkg::CfgDataW-1:0] cfg_data_i
);
  import sdno_pkg::*;

  localparam int IdxW = CoordBits - 2;

  logic [CoordBits-1:0] origin_x_q;
  logic [CoordBits-1:0] origin_y_q;
  logic                 value_neg_q;
  logic [ScaleW-1:0]    scale_q;
  logic [ColorW-1:0]    ink_q;

  digits_t     digits;
  digit_stat_t dstat;
  logic        bcd_start;

  logic adv;
  logic in_acc;

  logic                 s1_valid_q;
  logic [CoordBits-1:0] s1_relx_q;
  logic [CoordBits-1:0] s1_rely_q;
  logic                 s1_inside_q;

  logic                           dv_valid;
  logic [1:0][CoordBits-1:0]      dv_quot;
  logic                           dv_inside;

  logic [IdxW-1:0]      idx;
  logic [1:0]           col;
  logic                 sel_ok_d;

  logic                 sel_valid_q;
  logic                 sel_ok_q;
  logic [DigitCntW-1:0] sel_pos_q;
  logic [2:0]           sel_row_q;
  logic [1:0]           sel_col_q;

  logic     out_valid_q;
  pix_out_t out_q;
  logic     lit_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q  <= '0;
      origin_y_q  <= '0;
      value_neg_q <= 1'b0;
      scale_q     <= ScaleReset;
      ink_q       <= InkReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_ORIGIN_X:    origin_x_q  <= cfg_data_i[CoordBits-1:0];
        REG_ORIGIN_Y:    origin_y_q  <= cfg_data_i[CoordBits-1:0];
        REG_SHOWN_VALUE: value_neg_q <= cfg_data_i[ValueW-1];
        REG_SCALE:       scale_q     <= cfg_data_i[ScaleW-1:0];
        REG_INK_COLOR:   ink_q       <= cfg_data_i[ColorW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign bcd_start = cfg_we_i && (cfg_idx_i == REG_SHOWN_VALUE);

  sdno_bcd #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_bcd (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (bcd_start),
    .value_i  (cfg_data_i[ValueW-1:0]),
    .digits_o (digits),
    .stat_o   (dstat)
  );

  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv || dstat.busy;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      sel_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= in_acc;
      sel_valid_q <= dv_valid;
      out_valid_q <= sel_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_relx_q   <= in_data_i.pixel_x - origin_x_q;
      s1_rely_q   <= in_data_i.pixel_y - origin_y_q;
      s1_inside_q <= (in_data_i.pixel_x >= origin_x_q) && (in_data_i.pixel_y >= origin_y_q);
    end
  end

  sdno_div #(
    .W     (CoordBits),
    .NL    (2),
    .SW    (ScaleW),
    .TAG_W (1),
    .STEPS (DivSteps)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .valid_i    (s1_valid_q),
    .dividend_i ({s1_relx_q, s1_rely_q}),
    .divisor_i  (scale_q),
    .tag_i      (s1_inside_q),
    .valid_o    (dv_valid),
    .quot_o     (dv_quot),
    .tag_o      (dv_inside)
  );

  // lane 1 carries x, lane 0 carries y
  assign idx = dv_quot[1][CoordBits-1:2];
  assign col = dv_quot[1][1:0];

  assign sel_ok_d = dv_inside && !value_neg_q && (scale_q != '0)
                 && (idx < IdxW'(dstat.count)) && (col < 2'(GlyphCols))
                 && (dv_quot[0] < CoordBits'(GlyphRows));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sel_ok_q  <= sel_ok_d;
      sel_pos_q <= dstat.count - DigitCntW'(1) - idx[DigitCntW-1:0];
      sel_row_q <= dv_quot[0][2:0];
      sel_col_q <= col;
    end
  end

  assign lit_d = sel_ok_q && glyph_bit(digits[sel_pos_q], sel_row_q, sel_col_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.lit         <= lit_d;
      out_q.pixel_color <= lit_d ? ink_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dstat.busy |-> in_stall_o)
    else $error("input taken during digit conversion");

  a_dark_no_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.lit) |-> (out_data_o.pixel_color == '0))
    else $error("unlit pixel carries color");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(s1_valid_q) && $stable(sel_valid_q) && $stable(dv_valid)))
    else $error("pipeline moved while stalled");

endmodule

`default_nettype wire
